@@ hdl/pks_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pks_pkg
// Shared types, key codes and modifier bits for the held-key tracker.
// ----------------------------------------------------------------------------
package pks_pkg;

    // Width of one evdev key code
    localparam int KEY_W = 10;

    // Width of the modifier masks and of the count field on the result word
    localparam int MASK_W  = 4;
    localparam int COUNT_W = 5;

    // Bus widths, padded to whole bytes
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 16;

    // Input word kinds (carried on s_tuser)
    localparam logic CMD_KEY   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // evdev modifier codes
    localparam logic [KEY_W-1:0] EV_LSHIFT = 10'd42;
    localparam logic [KEY_W-1:0] EV_RSHIFT = 10'd54;
    localparam logic [KEY_W-1:0] EV_LCTRL  = 10'd29;
    localparam logic [KEY_W-1:0] EV_RCTRL  = 10'd97;
    localparam logic [KEY_W-1:0] EV_LALT   = 10'd56;
    localparam logic [KEY_W-1:0] EV_RALT   = 10'd100;
    localparam logic [KEY_W-1:0] EV_CAPS   = 10'd58;

    // Mask bits
    localparam logic [MASK_W-1:0] BIT_NONE  = 4'b0000;
    localparam logic [MASK_W-1:0] BIT_SHIFT = 4'b0001;
    localparam logic [MASK_W-1:0] BIT_CAPS  = 4'b0010;
    localparam logic [MASK_W-1:0] BIT_CTRL  = 4'b0100;
    localparam logic [MASK_W-1:0] BIT_ALT   = 4'b1000;

    // Sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } pks_state_t;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic             capture;  // word accepted: compare key in every cell
        logic             shift;    // release of a held key: close the gap
        logic             append;   // press of an absent key: write at the end
        logic [KEY_W-1:0] key;
    } pks_cell_ctl_t;

    // Modifier bit of a key code, none for ordinary keys
    function automatic logic [MASK_W-1:0] pks_mod_bit(input logic [KEY_W-1:0] code);
        logic [MASK_W-1:0] bits;
        case (code)
            EV_LSHIFT, EV_RSHIFT: bits = BIT_SHIFT;
            EV_LCTRL, EV_RCTRL:   bits = BIT_CTRL;
            EV_LALT, EV_RALT:     bits = BIT_ALT;
            EV_CAPS:              bits = BIT_CAPS;
            default:              bits = BIT_NONE;
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

@@ hdl/pks_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pks_cell
// One slot of the held-key list: holds a code, compares it with the key and
// takes its right-hand neighbour's code when it or an earlier slot is freed.
// ----------------------------------------------------------------------------
module pks_cell (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire pks_pkg::pks_cell_ctl_t      ctl,
    input  wire logic                        occupied,   // slot lies below the count
    input  wire logic                        append_sel, // slot is the first free one
    input  wire logic                        rm_in,      // match somewhere to the left
    input  wire logic [pks_pkg::KEY_W-1:0]   next_code,  // neighbour's code
    output logic                             rm_out,
    output logic                             hit,
    output logic [pks_pkg::KEY_W-1:0]        code
);
    import pks_pkg::*;

    logic [KEY_W-1:0] code_reg;
    logic             hit_reg;

    // Compare on accept; result held for the update cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (ctl.capture) begin
            hit_reg <= occupied && (code_reg == ctl.key);
        end
    end

    // Slots at or after the match move down by one
    assign rm_out = rm_in | hit_reg;

    always_ff @(posedge aclk) begin
        if (ctl.shift && rm_out) begin
            code_reg <= next_code;
        end else if (ctl.append && append_sel) begin
            code_reg <= ctl.key;
        end
    end

    assign hit  = hit_reg;
    assign code = code_reg;

endmodule
`default_nettype wire

@@ hdl/pks_mods.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pks_mods
// Depressed and locked modifier masks, updated once per word.
// ----------------------------------------------------------------------------
module pks_mods (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         commit,
    input  wire logic                         clear,
    input  wire logic [pks_pkg::KEY_W-1:0]    key,
    input  wire logic                         press,
    output logic [pks_pkg::MASK_W-1:0]        held_next,
    output logic [pks_pkg::MASK_W-1:0]        lock_next
);
    import pks_pkg::*;

    logic [MASK_W-1:0] held_reg;
    logic [MASK_W-1:0] lock_reg;
    logic [MASK_W-1:0] mod;

    // Caps press toggles the lock; other modifiers follow press/release
    always_comb begin
        mod       = pks_mod_bit(key);
        held_next = held_reg;
        lock_next = lock_reg;
        if (commit) begin
            if (clear) begin
                held_next = BIT_NONE;
            end else if (mod != BIT_NONE) begin
                if ((key == EV_CAPS) && press) begin
                    lock_next = lock_reg ^ mod;
                end else if (press) begin
                    held_next = held_reg | mod;
                end else begin
                    held_next = held_reg & ~mod;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= BIT_NONE;
            lock_reg <= BIT_NONE;
        end else begin
            held_reg <= held_next;
            lock_reg <= lock_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/pressed_key_set_with_modifiers_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pressed_key_set_with_modifiers_top
// Held-key list with depressed and locked modifier masks.
// ----------------------------------------------------------------------------
// For each input word, in the accept cycle (ST_IDLE) every cell of the
// KEY_SLOTS-long chain compares its stored code with the key. Then, in
// ST_UPDATE, the list is updated (append at the end, or every cell from the
// match on takes its neighbour's code) while the result word is loaded into
// the output register. A new word is taken once the sequencer is back in
// ST_IDLE, even if the previous result still waits on m_tready; the update
// stalls only while that result is not taken. One result word per input word.
// ----------------------------------------------------------------------------
module pressed_key_set_with_modifiers_top #(
    parameter int KEY_SLOTS = 16
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input words
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pks_pkg::S_DATA_W-1:0]   s_tdata,  // [9:0] key_code, [10] is_press
    input  wire logic                           s_tuser,  // [0] command
    // Result words
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pks_pkg::M_DATA_W-1:0]        m_tdata   // [3:0] mods_held, [7:4] mods_lock,
                                                          // [12:8] held_count
);
    import pks_pkg::*;

    localparam int CNT_W = $clog2(KEY_SLOTS + 1);

    pks_state_t          state_reg, state_next;
    logic                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic                press_reg;
    logic [CNT_W-1:0]    total_reg, total_next;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic                m_tvalid_reg;

    logic                accept, commit, found, full, do_add, do_rm;
    pks_cell_ctl_t       ctl;
    logic [MASK_W-1:0]   held_next, lock_next;

    logic [KEY_SLOTS:0]  rm_chain;
    logic [KEY_SLOTS-1:0] hits;
    logic [KEY_W-1:0]    codes [KEY_SLOTS];

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                commit = !m_tvalid_reg || m_tready;
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Latch the word
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= s_tuser;
            key_reg   <= s_tdata[KEY_W-1:0];
            press_reg <= s_tdata[KEY_W];
        end
    end

    // List update decisions
    assign found  = rm_chain[KEY_SLOTS];
    assign full   = (total_reg == CNT_W'(KEY_SLOTS));
    assign do_add = commit && (cmd_reg == CMD_KEY) && press_reg && !found && !full;
    assign do_rm  = commit && (cmd_reg == CMD_KEY) && !press_reg && found;

    always_comb begin
        total_next = total_reg;
        if (commit && (cmd_reg == CMD_CLEAR)) begin
            total_next = '0;
        end else if (do_add) begin
            total_next = total_reg + CNT_W'(1);
        end else if (do_rm) begin
            total_next = total_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
        end else begin
            total_reg <= total_next;
        end
    end

    // Cell chain
    always_comb begin
        ctl.capture = accept;
        ctl.shift   = do_rm;
        ctl.append  = do_add;
        ctl.key     = (state_reg == ST_IDLE) ? s_tdata[KEY_W-1:0] : key_reg;
    end

    assign rm_chain[0] = 1'b0;

    for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_cell
        logic [KEY_W-1:0] nbr;
        if (i == KEY_SLOTS - 1) begin : g_last
            assign nbr = codes[i];
        end else begin : g_mid
            assign nbr = codes[i+1];
        end

        pks_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .occupied   (CNT_W'(i) < total_reg),
            .append_sel (CNT_W'(i) == total_reg),
            .rm_in      (rm_chain[i]),
            .next_code  (nbr),
            .rm_out     (rm_chain[i+1]),
            .hit        (hits[i]),
            .code       (codes[i])
        );
    end

    // Modifier masks
    pks_mods u_mods (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .commit    (commit),
        .clear     (cmd_reg == CMD_CLEAR),
        .key       (key_reg),
        .press     (press_reg),
        .held_next (held_next),
        .lock_next (lock_next)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_tdata_reg <= {(M_DATA_W - COUNT_W - 2 * MASK_W)'(0),
                            COUNT_W'(total_next), lock_next, held_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // Count never exceeds the slot count
    a_total_range: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CNT_W'(KEY_SLOTS))
        else $error("held count above slot count");

    // Codes in the list are unique, so at most one cell matches
    a_single_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(hits))
        else $error("more than one cell matched the key");

    // A clear empties the list
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (cmd_reg == CMD_CLEAR) |=> total_reg == '0)
        else $error("clear left keys in the list");

    // A press of a key already held leaves the count alone
    a_repeat_press: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (cmd_reg == CMD_KEY) && press_reg && found |=> $stable(total_reg))
        else $error("repeated press changed the count");

    // No update while a result is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && !m_tready |-> !commit)
        else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire
